[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHECK_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg)
`define CHECK_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[rtl/pbma_pkg.sv]
package pbma_pkg;

   localparam int SLOTS_DEFAULT = 128;

   localparam int BOUND_W = 8;
   localparam int COUNT_W = 8;
   localparam int MODE_W  = 2;
   localparam int POOL_W  = 2;
   localparam int CSR_INDEX_W = 2;

   localparam logic [BOUND_W-1:0] POOL0_END_RESET = 8'd14;
   localparam logic [BOUND_W-1:0] POOL1_END_RESET = 8'd28;
   localparam logic [BOUND_W-1:0] POOL2_END_RESET = 8'd84;

   localparam logic [CSR_INDEX_W-1:0] CSR_POOL0_END = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL1_END = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL2_END = 2'd2;

   localparam logic [MODE_W-1:0] MODE_BOOK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;

   localparam logic [POOL_W-1:0] POOL_0    = 2'd0;
   localparam logic [POOL_W-1:0] POOL_1    = 2'd1;
   localparam logic [POOL_W-1:0] POOL_NONE = 2'd3;

   // one step of the rotating bitmap
   typedef struct packed {
      logic shift;
      logic zero;
      logic mark;
   } bm_ctrl_type;

   typedef struct packed {
      logic               valid;
      logic               granted;
      logic [COUNT_W-1:0] free_count;
   } result_type;

endpackage

[rtl/pbma_bitmap.sv]
module pbma_bitmap #(
   parameter int SLOTS = pbma_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pbma_pkg::bm_ctrl_type  ctl,
   output logic                   head_bit
);

   logic [SLOTS-1:0] bitmap_ff;
   logic [SLOTS-1:0] bitmap_in;
   logic             new_bit;

   assign head_bit = bitmap_ff[0];

   // slot under the head leaves at bit 0 and re-enters at the top
   always_comb begin
      new_bit   = ctl.zero ? 1'b0 : (bitmap_ff[0] | ctl.mark);
      bitmap_in = bitmap_ff;
      if (ctl.shift) begin
         bitmap_in = {new_bit, bitmap_ff[SLOTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff <= '0;
      end else begin
         bitmap_ff <= bitmap_in;
      end
   end

endmodule

[rtl/pbma_ctrl.sv]
`include "assert_macros.svh"

module pbma_ctrl #(
   parameter int SLOTS = pbma_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pbma_pkg::MODE_W-1:0]      mode,
   input  logic [pbma_pkg::POOL_W-1:0]      pool,
   input  logic [pbma_pkg::COUNT_W-1:0]     request_count,
   output logic                             idle,
   input  logic [pbma_pkg::BOUND_W-1:0]     pool0_end,
   input  logic [pbma_pkg::BOUND_W-1:0]     pool1_end,
   input  logic [pbma_pkg::BOUND_W-1:0]     pool2_end,
   input  logic                             head_bit,
   output pbma_pkg::bm_ctrl_type            bm_ctl,
   input  logic                             out_busy,
   output pbma_pkg::result_type             result
);

   localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW   = $clog2(SLOTS + 1);
   localparam int CMPW = (PW > pbma_pkg::BOUND_W) ? PW : pbma_pkg::BOUND_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_COUNT  = 2'd1;
   localparam logic [1:0] ST_MARK   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [1:0] OP_BOOK  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [1:0]                     op_ff, op_in;
   logic [pbma_pkg::POOL_W-1:0]    pool_ff, pool_in;
   logic [pbma_pkg::COUNT_W-1:0]   want_ff, want_in;
   logic [pbma_pkg::COUNT_W-1:0]   remain_ff, remain_in;
   logic [IW-1:0]                  pos_ff, pos_in;
   logic [PW-1:0]                  cnt_ff, cnt_in;
   logic                           granted_ff, granted_in;

   logic [pbma_pkg::BOUND_W-1:0]   lo, hi;
   logic [CMPW-1:0]                pos_w, cnt_w, step_w;
   logic                           in_range, last, free_bit, mark;
   logic [PW-1:0]                  cnt_step;

   assign idle = (state_ff == ST_IDLE);

   // pool window
   always_comb begin
      lo = '0;
      hi = pool2_end;
      if (op_ff == OP_BOOK) begin
         case (pool_ff)
            pbma_pkg::POOL_0: begin
               lo = '0;
               hi = pool0_end;
            end
            pbma_pkg::POOL_1: begin
               lo = pool0_end;
               hi = pool1_end;
            end
            default: begin
               lo = pool1_end;
               hi = pool2_end;
            end
         endcase
      end
   end

   assign pos_w    = CMPW'(pos_ff);
   assign in_range = (pos_w >= CMPW'(lo)) && (pos_w < CMPW'(hi));
   assign last     = (pos_ff == IW'(SLOTS - 1));
   assign free_bit = in_range && ((op_ff == OP_CLEAR) || !head_bit);
   assign cnt_step = cnt_ff + PW'(free_bit);
   assign step_w   = CMPW'(cnt_step);
   assign cnt_w    = CMPW'(cnt_ff);
   assign mark     = in_range && !head_bit && (remain_ff != '0);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      pool_in    = pool_ff;
      want_in    = want_ff;
      remain_in  = remain_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      granted_in = granted_ff;
      bm_ctl     = '0;
      result     = '0;
      result.granted    = granted_ff;
      result.free_count = (cnt_w > CMPW'(255)) ? 8'hFF : cnt_w[7:0];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (mode == pbma_pkg::MODE_BOOK && pool != pbma_pkg::POOL_NONE) begin
                  op_in = OP_BOOK;
               end else if (mode == pbma_pkg::MODE_CLEAR) begin
                  op_in = OP_CLEAR;
               end else begin
                  op_in = OP_QUERY;
               end
               pool_in    = pool;
               want_in    = request_count;
               remain_in  = request_count;
               pos_in     = '0;
               cnt_in     = '0;
               granted_in = 1'b0;
               state_in   = ST_COUNT;
            end
         end
         ST_COUNT: begin
            bm_ctl.shift = 1'b1;
            bm_ctl.zero  = (op_ff == OP_CLEAR);
            cnt_in       = cnt_step;
            pos_in       = last ? '0 : pos_ff + IW'(1);
            if (last) begin
               if (op_ff == OP_BOOK && want_ff != '0 && CMPW'(want_ff) <= step_w) begin
                  state_in = ST_MARK;
               end else begin
                  granted_in = (op_ff == OP_CLEAR);
                  state_in   = ST_FINISH;
               end
            end
         end
         ST_MARK: begin
            bm_ctl.shift = 1'b1;
            bm_ctl.mark  = mark;
            remain_in    = remain_ff - pbma_pkg::COUNT_W'(mark);
            pos_in       = last ? '0 : pos_ff + IW'(1);
            if (last) begin
               cnt_in     = cnt_ff - PW'(want_ff);
               granted_in = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_busy) begin
               result.valid = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pool_ff    <= pool_in;
      want_ff    <= want_in;
      remain_ff  <= remain_in;
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      granted_ff <= granted_in;
   end

   `CHECK_IMPLY(a_mark_complete, clock, reset, state_ff == ST_MARK && last, remain_in == '0, "booking left slots unmarked")
   `CHECK_IMPLY(a_mark_only_book, clock, reset, state_ff == ST_MARK, op_ff == OP_BOOK, "marking pass outside a booking")
   `CHECK_NEVER(a_no_overwrite, clock, reset, result.valid && out_busy, "result issued while output word still held")

endmodule

[rtl/partitioned_bitmap_multi_allocator.sv]
// channel   ports        tdata fields (lsb first)
// request   req_t*       mode[1:0], pool[3:2], request_count[11:4], zero[15:12]
// response  rsp_t*       granted[0], free_count[8:1], zero[15:9]
// csr       csr_*        write only, index 0..2 = pool0_end, pool1_end, pool2_end
//
// query and clear take one counting pass, a granted booking a second, marking pass:
// the bitmap rotates through one shift register and is read one slot per cycle.
// one word is worked on at a time; the next is taken once the result is loaded
// into the response register, even while that word waits on rsp_tready.
// synchronous reset frees every slot and restores the pool boundaries 14, 28, 84.
`include "assert_macros.svh"

module partitioned_bitmap_multi_allocator #(
   parameter int SLOTS = pbma_pkg::SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // mode, pool, request_count
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // granted, free_count
   input  logic                                csr_we,
   input  logic [pbma_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbma_pkg::BOUND_W-1:0]        csr_wdata
);

   logic [pbma_pkg::BOUND_W-1:0] pool0_end_ff, pool0_end_in;
   logic [pbma_pkg::BOUND_W-1:0] pool1_end_ff, pool1_end_in;
   logic [pbma_pkg::BOUND_W-1:0] pool2_end_ff, pool2_end_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_granted_ff, rsp_granted_in;
   logic [pbma_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                         idle, head_bit, start, out_busy;
   pbma_pkg::bm_ctrl_type        bm_ctl;
   pbma_pkg::result_type         result;

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_granted_ff};

   always_comb begin
      pool0_end_in = pool0_end_ff;
      pool1_end_in = pool1_end_ff;
      pool2_end_in = pool2_end_ff;
      if (csr_we) begin
         case (csr_index)
            pbma_pkg::CSR_POOL0_END: pool0_end_in = csr_wdata;
            pbma_pkg::CSR_POOL1_END: pool1_end_in = csr_wdata;
            pbma_pkg::CSR_POOL2_END: pool2_end_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_count_in   = rsp_count_ff;
      if (result.valid) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = result.granted;
         rsp_count_in   = result.free_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool0_end_ff <= pbma_pkg::POOL0_END_RESET;
         pool1_end_ff <= pbma_pkg::POOL1_END_RESET;
         pool2_end_ff <= pbma_pkg::POOL2_END_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool0_end_ff <= pool0_end_in;
         pool1_end_ff <= pool1_end_in;
         pool2_end_ff <= pool2_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_granted_ff <= rsp_granted_in;
      rsp_count_ff   <= rsp_count_in;
   end

   pbma_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .mode          (req_tdata[1:0]),
      .pool          (req_tdata[3:2]),
      .request_count (req_tdata[11:4]),
      .idle          (idle),
      .pool0_end     (pool0_end_ff),
      .pool1_end     (pool1_end_ff),
      .pool2_end     (pool2_end_ff),
      .head_bit      (head_bit),
      .bm_ctl        (bm_ctl),
      .out_busy      (out_busy),
      .result        (result)
   );

   pbma_bitmap #(
      .SLOTS (SLOTS)
   ) u_bitmap (
      .clock    (clock),
      .reset    (reset),
      .ctl      (bm_ctl),
      .head_bit (head_bit)
   );

   `CHECK_IMPLY(a_busy_no_accept, clock, reset, !idle, !req_tready, "request taken while a word is in work")

endmodule
